[hdl/psc_pkg.sv]
// Package for the PTH sensor compensation unit.
// Holds register indexes, latencies and fixed-point helpers; no dependencies.
package psc_pkg;

   typedef enum logic [2:0] {
      CSR_TEMP       = 3'd0,
      CSR_PRESS_LOW  = 3'd1,
      CSR_PRESS_HIGH = 3'd2,
      CSR_P9_H1      = 3'd3,
      CSR_HUMID      = 3'd4
   } csr_index_type;

   localparam int unsigned LAT_TEMP      = 4;
   localparam int unsigned LAT_PRESS_PRE = 5;
   localparam int unsigned LAT_DIV       = 32;
   localparam int unsigned LAT_PRESS_PST = 4;
   localparam int unsigned LAT_HUMID     = 12;
   localparam int unsigned LAT_PRESS     = LAT_PRESS_PRE + LAT_DIV + LAT_PRESS_PST;
   localparam int unsigned LAT_TOTAL     = LAT_TEMP + LAT_PRESS;

   typedef struct packed {
      logic half;   // dividend taken unshifted, quotient doubled after
      logic zero;   // divisor was zero
   } div_side_type;

   function automatic logic [31:0] sx16(logic [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

   function automatic logic [31:0] sx12(logic [11:0] v);
      return {{20{v[11]}}, v};
   endfunction

   function automatic logic [31:0] sx8(logic [7:0] v);
      return {{24{v[7]}}, v};
   endfunction

   function automatic logic [31:0] asr(logic [31:0] x, int unsigned n);
      return 32'($signed(x) >>> n);
   endfunction

   // signed divide by 2**n, truncating toward zero
   function automatic logic [31:0] sdivp2(logic [31:0] x, int unsigned n);
      logic [31:0] bias;
      bias = (32'd1 << n) - 32'd1;
      return asr(x + (x[31] ? bias : 32'd0), n);
   endfunction

endpackage

[hdl/psc_delay.sv]
// Enabled shift-register delay line for aligning pipeline side paths.
// No package dependencies.
module psc_delay #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 4
) (
   input  logic             clock,
   input  logic             adv,
   input  logic [WIDTH-1:0] din,
   output logic [WIDTH-1:0] dout
);
   logic [WIDTH-1:0] data_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (adv) begin
         data_ff[0] <= din;
         for (int i = 1; i < DEPTH; i++) begin
            data_ff[i] <= data_ff[i-1];
         end
      end
   end

   assign dout = data_ff[DEPTH-1];
endmodule

[hdl/psc_temp.sv]
// Temperature compensation, four stages; yields fine-temperature terms.
// Depends on psc_pkg.
module psc_temp import psc_pkg::*; (
   input  logic        clock,
   input  logic        adv,
   input  logic [19:0] ut,
   input  logic [19:0] up,
   input  logic [15:0] uh,
   input  logic [47:0] cal_temp,
   output logic [31:0] temp,
   output logic [31:0] pa,
   output logic [31:0] v1,
   output logic [19:0] up_o,
   output logic [15:0] uh_o
);
   logic [31:0] t1, t2, t3, x_in, d_in;
   logic [31:0] ta_ff, dd_ff, a_ff, b1_ff, tf_ff, temp_ff, pa_ff, v1_ff;
   logic [19:0] up_ff [LAT_TEMP];
   logic [15:0] uh_ff [LAT_TEMP];

   assign t1   = 32'(cal_temp[15:0]);
   assign t2   = sx16(cal_temp[31:16]);
   assign t3   = sx16(cal_temp[47:32]);
   assign x_in = (32'(ut) >> 3) - (t1 << 1);
   assign d_in = (32'(ut) >> 4) - t1;

   always_ff @(posedge clock) begin
      if (adv) begin
         ta_ff   <= x_in * t2;
         dd_ff   <= d_in * d_in;
         a_ff    <= asr(ta_ff, 11);
         b1_ff   <= asr(dd_ff, 12) * t3;
         tf_ff   <= a_ff + asr(b1_ff, 14);
         temp_ff <= asr(tf_ff * 32'd5 + 32'd128, 8);
         pa_ff   <= asr(tf_ff, 1) - 32'd64000;
         v1_ff   <= tf_ff - 32'd76800;
         up_ff[0] <= up;
         uh_ff[0] <= uh;
         for (int i = 1; i < LAT_TEMP; i++) begin
            up_ff[i] <= up_ff[i-1];
            uh_ff[i] <= uh_ff[i-1];
         end
      end
   end

   assign temp = temp_ff;
   assign pa   = pa_ff;
   assign v1   = v1_ff;
   assign up_o = up_ff[LAT_TEMP-1];
   assign uh_o = uh_ff[LAT_TEMP-1];
endmodule

[hdl/psc_press_pre.sv]
// Pressure front end: forms divisor and dividend over five stages.
// Depends on psc_pkg.
module psc_press_pre import psc_pkg::*; (
   input  logic         clock,
   input  logic         adv,
   input  logic [31:0]  pa,
   input  logic [19:0]  up,
   input  logic [63:0]  cal_lo,
   input  logic [63:0]  cal_hi,
   output logic [31:0]  den,
   output logic [31:0]  dvd,
   output div_side_type side
);
   logic [31:0] p1, p2, p3, p4, p5, p6, a2;
   logic [31:0] sq_ff, ap5_ff, p2a_ff, b6_ff, c_ff, ap5b_ff, p2ab_ff;
   logic [31:0] bb_ff, ac_ff, m_ff, num_ff, den_ff, dvd_ff, bsum;
   logic [19:0] up1_ff, up2_ff, up3_ff;
   div_side_type side_ff;

   assign p1   = 32'(cal_lo[15:0]);
   assign p2   = sx16(cal_lo[31:16]);
   assign p3   = sx16(cal_lo[47:32]);
   assign p4   = sx16(cal_lo[63:48]);
   assign p5   = sx16(cal_hi[15:0]);
   assign p6   = sx16(cal_hi[31:16]);
   assign a2   = asr(pa, 2);
   assign bsum = b6_ff + (ap5b_ff << 1);

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_ff   <= a2 * a2;
         ap5_ff  <= pa * p5;
         p2a_ff  <= p2 * pa;
         up1_ff  <= up;
         b6_ff   <= asr(sq_ff, 11) * p6;
         c_ff    <= p3 * asr(sq_ff, 13);
         ap5b_ff <= ap5_ff;
         p2ab_ff <= p2a_ff;
         up2_ff  <= up1_ff;
         bb_ff   <= asr(bsum, 2) + (p4 << 16);
         ac_ff   <= asr(asr(c_ff, 3) + asr(p2ab_ff, 1), 18);
         up3_ff  <= up2_ff;
         m_ff    <= (32'd32768 + ac_ff) * p1;
         num_ff  <= ((32'd1048576 - 32'(up3_ff)) - asr(bb_ff, 12)) * 32'd3125;
         den_ff  <= asr(m_ff, 15);
         dvd_ff  <= num_ff[31] ? num_ff : (num_ff << 1);
         side_ff.half <= num_ff[31];
         side_ff.zero <= (asr(m_ff, 15) == 32'd0);
      end
   end

   assign den  = den_ff;
   assign dvd  = dvd_ff;
   assign side = side_ff;
endmodule

[hdl/psc_divider.sv]
// Pipelined unsigned 32/32 restoring divider, one quotient bit per stage.
// Depends on psc_pkg.
module psc_divider import psc_pkg::*; (
   input  logic        clock,
   input  logic        adv,
   input  logic [31:0] dvd,
   input  logic [31:0] den,
   output logic [31:0] quo
);
   logic [31:0] rem_ff [LAT_DIV];
   logic [31:0] n_ff   [LAT_DIV];
   logic [31:0] q_ff   [LAT_DIV];
   logic [31:0] d_ff   [LAT_DIV];
   logic [31:0] rem_in [LAT_DIV];
   logic [31:0] n_in   [LAT_DIV];
   logic [31:0] q_in   [LAT_DIV];
   logic [31:0] d_in   [LAT_DIV];

   always_comb begin
      logic [32:0] r;
      logic        ge;
      logic [31:0] rp, np, qp, dp;
      for (int k = 0; k < LAT_DIV; k++) begin
         if (k == 0) begin
            rp = 32'd0;
            np = dvd;
            qp = 32'd0;
            dp = den;
         end else begin
            rp = rem_ff[k-1];
            np = n_ff[k-1];
            qp = q_ff[k-1];
            dp = d_ff[k-1];
         end
         r = {rp, np[31]};
         ge = (r >= {1'b0, dp});
         rem_in[k] = ge ? 32'(r - {1'b0, dp}) : r[31:0];
         n_in[k]   = np << 1;
         q_in[k]   = {qp[30:0], ge};
         d_in[k]   = dp;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < LAT_DIV; k++) begin
            rem_ff[k] <= rem_in[k];
            n_ff[k]   <= n_in[k];
            q_ff[k]   <= q_in[k];
            d_ff[k]   <= d_in[k];
         end
      end
   end

   assign quo = q_ff[LAT_DIV-1];
endmodule

[hdl/psc_press_post.sv]
// Pressure back end: quotient scaling and P7..P9 correction, four stages.
// Depends on psc_pkg.
module psc_press_post import psc_pkg::*; (
   input  logic         clock,
   input  logic         adv,
   input  logic [31:0]  quo,
   input  div_side_type side,
   input  logic [63:0]  cal_hi,
   input  logic [23:0]  cal_p9h1,
   output logic [31:0]  pres
);
   logic [31:0] p7, p8, p9, p0_ff, p1_ff, p2_ff, sqq_ff, pb_ff, a9_ff, b8_ff, pres_ff;
   logic        z0_ff, z1_ff, z2_ff;

   assign p7 = sx16(cal_hi[47:32]);
   assign p8 = sx16(cal_hi[63:48]);
   assign p9 = sx16(cal_p9h1[15:0]);

   always_ff @(posedge clock) begin
      if (adv) begin
         p0_ff   <= side.half ? (quo << 1) : quo;
         z0_ff   <= side.zero;
         sqq_ff  <= (p0_ff >> 3) * (p0_ff >> 3);
         pb_ff   <= (p0_ff >> 2) * p8;
         p1_ff   <= p0_ff;
         z1_ff   <= z0_ff;
         a9_ff   <= asr(p9 * (sqq_ff >> 13), 12);
         b8_ff   <= asr(pb_ff, 13);
         p2_ff   <= p1_ff;
         z2_ff   <= z1_ff;
         pres_ff <= z2_ff ? 32'd0 : p2_ff + asr(a9_ff + b8_ff + p7, 4);
      end
   end

   assign pres = pres_ff;
endmodule

[hdl/psc_humid.sv]
// Humidity compensation, twelve stages, with clamp and unsigned Q7.10 output.
// Depends on psc_pkg.
module psc_humid import psc_pkg::*; (
   input  logic        clock,
   input  logic        adv,
   input  logic [31:0] v1,
   input  logic [15:0] uh,
   input  logic [23:0] cal_p9h1,
   input  logic [55:0] cal_humid,
   output logic [16:0] hum
);
   logic [31:0] h1, h2, h3, h4, h5, h6, hv;
   logic [31:0] pre_ff, v4a_ff, t6_ff, t3_ff, v5_ff [5], w2_ff, w3_ff;
   logic [31:0] m_ff, x4_ff, mm_ff, y2_ff, v3_ff [5], q_ff, qq_ff, z4_ff, hm_ff;
   logic [16:0] hum_ff;

   assign h1 = 32'(cal_p9h1[23:16]);
   assign h2 = sx16(cal_humid[15:0]);
   assign h3 = 32'(cal_humid[23:16]);
   assign h4 = sx12(cal_humid[35:24]);
   assign h5 = sx12(cal_humid[47:36]);
   assign h6 = sx8(cal_humid[55:48]);
   assign hv = v3_ff[4] - sdivp2(hm_ff, 4);

   always_ff @(posedge clock) begin
      if (adv) begin
         pre_ff   <= (32'(uh) << 14) - (h4 << 20) + 32'd16384;
         v4a_ff   <= h5 * v1;
         t6_ff    <= v1 * h6;
         t3_ff    <= v1 * h3;
         v5_ff[0] <= sdivp2(pre_ff - v4a_ff, 15);
         w2_ff    <= sdivp2(t6_ff, 10);
         w3_ff    <= sdivp2(t3_ff, 11);
         m_ff     <= w2_ff * (w3_ff + 32'd32768);
         x4_ff    <= sdivp2(m_ff, 10) + 32'd2097152;
         mm_ff    <= x4_ff * h2;
         y2_ff    <= sdivp2(mm_ff + 32'd8192, 14);
         for (int i = 1; i < 5; i++) begin
            v5_ff[i] <= v5_ff[i-1];
         end
         v3_ff[0] <= v5_ff[4] * y2_ff;
         for (int i = 1; i < 5; i++) begin
            v3_ff[i] <= v3_ff[i-1];
         end
         q_ff     <= sdivp2(v3_ff[0], 15);
         qq_ff    <= q_ff * q_ff;
         z4_ff    <= sdivp2(qq_ff, 7);
         hm_ff    <= z4_ff * h1;
         if (hv[31]) begin
            hum_ff <= 17'd0;
         end else if (hv > 32'd419430400) begin
            hum_ff <= 17'd102400;
         end else begin
            hum_ff <= hv[28:12];
         end
      end
   end

   assign hum = hum_ff;
endmodule

[hdl/pth_sensor_compensation_unit.sv]
// PTH sensor compensation unit: temperature, pressure and humidity datapath.
// Takes one item per cycle from req to rsp while a valid rsp is not stalled.
// Depth set by the 32-stage pressure divider plus 13 arithmetic stages.
// A stalled rsp holds the whole pipeline; reset clears valid bits and CSRs.
// Depends on psc_pkg and the psc_* stage modules.
module pth_sensor_compensation_unit import psc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [19:0] req_raw_pressure,
   input  logic [19:0] req_raw_temperature,
   input  logic [15:0] req_raw_humidity,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_temperature_centi,
   output logic [31:0] rsp_pressure_pa,
   output logic [16:0] rsp_humidity_q10,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata
);
   logic [47:0] cal_temp_ff;
   logic [63:0] cal_lo_ff, cal_hi_ff;
   logic [23:0] cal_p9h1_ff;
   logic [55:0] cal_humid_ff;
   logic [LAT_TOTAL-1:0] valid_ff;
   logic adv;
   logic [31:0] temp, pa, v1, den, dvd, quo;
   logic [19:0] up_t;
   logic [15:0] uh_t;
   logic [16:0] hum;
   div_side_type side, side_d;

   assign adv       = !(valid_ff[LAT_TOTAL-1] && rsp_stall);
   assign req_stall = !adv;
   assign rsp_valid = valid_ff[LAT_TOTAL-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_temp_ff  <= '0;
         cal_lo_ff    <= '0;
         cal_hi_ff    <= '0;
         cal_p9h1_ff  <= '0;
         cal_humid_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_TEMP:       cal_temp_ff  <= csr_wdata[47:0];
            CSR_PRESS_LOW:  cal_lo_ff    <= csr_wdata;
            CSR_PRESS_HIGH: cal_hi_ff    <= csr_wdata;
            CSR_P9_H1:      cal_p9h1_ff  <= csr_wdata[23:0];
            CSR_HUMID:      cal_humid_ff <= csr_wdata[55:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[LAT_TOTAL-2:0], req_valid};
      end
   end

   psc_temp u_temp (
      .clock, .adv, .ut(req_raw_temperature), .up(req_raw_pressure),
      .uh(req_raw_humidity), .cal_temp(cal_temp_ff), .temp, .pa, .v1,
      .up_o(up_t), .uh_o(uh_t)
   );

   psc_press_pre u_press_pre (
      .clock, .adv, .pa, .up(up_t), .cal_lo(cal_lo_ff), .cal_hi(cal_hi_ff),
      .den, .dvd, .side
   );

   psc_divider u_divider (.clock, .adv, .dvd, .den, .quo);

   psc_delay #(.WIDTH($bits(div_side_type)), .DEPTH(LAT_DIV)) u_side_dly (
      .clock, .adv, .din(side), .dout(side_d)
   );

   psc_press_post u_press_post (
      .clock, .adv, .quo, .side(side_d), .cal_hi(cal_hi_ff),
      .cal_p9h1(cal_p9h1_ff), .pres(rsp_pressure_pa)
   );

   psc_delay #(.WIDTH(32), .DEPTH(LAT_PRESS)) u_temp_dly (
      .clock, .adv, .din(temp), .dout(rsp_temperature_centi)
   );

   psc_humid u_humid (
      .clock, .adv, .v1, .uh(uh_t), .cal_p9h1(cal_p9h1_ff),
      .cal_humid(cal_humid_ff), .hum
   );

   psc_delay #(.WIDTH(17), .DEPTH(LAT_PRESS - LAT_HUMID)) u_humid_dly (
      .clock, .adv, .din(hum), .dout(rsp_humidity_q10)
   );
endmodule
